// ===== rtl/core/rpas_pkg.sv =====
`timescale 1ns / 1ps

package rpas_pkg;

  localparam int unsigned MaxAnchorsDef = 8;
  localparam int unsigned IdW           = 8;
  localparam int unsigned DistW         = 24;
  localparam int unsigned RssiW         = 16;
  localparam int unsigned DiffW         = 17;
  localparam int unsigned CountW        = 4;
  localparam int unsigned CfgAddrW      = 3;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned TdataW        = 64;

  typedef enum logic [CfgAddrW-1:0] {
    REG_REGION_IDS    = 3'd0,
    REG_REGION_COUNT  = 3'd1,
    REG_CHECK_MODE    = 3'd2,
    REG_DIST_MIN      = 3'd3,
    REG_DIST_MAX      = 3'd4,
    REG_RSSI_DIFF_MIN = 3'd5,
    REG_RSSI_DIFF_MAX = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic           reload;
    logic           step;
    logic           last;
    logic           qual;
    logic [IdW-1:0] id;
  } cell_bcast_t;

endpackage

// ===== rtl/core/rpas_cell.sv =====
`timescale 1ns / 1ps

module rpas_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rpas_pkg::cell_bcast_t     bcast_i,
  input  logic                      active_i,
  input  logic                      tail_i,
  input  logic [rpas_pkg::IdW-1:0]  load_id_i,
  input  logic [rpas_pkg::IdW-1:0]  next_id_i,
  input  logic [rpas_pkg::IdW-1:0]  tail_id_i,
  input  logic                      blocked_i,
  output logic                      blocked_o,
  output logic                      take_o,
  output logic [rpas_pkg::IdW-1:0]  id_o
);
  import rpas_pkg::*;

  logic [IdW-1:0] id_q;
  logic           seen_q;
  logic           hit_q;
  logic           match;
  logic           new_hit;

  assign match     = bcast_i.step & active_i & (id_q == bcast_i.id) & ~seen_q;
  assign new_hit   = match & bcast_i.qual;
  assign take_o    = new_hit & ~blocked_i;
  assign blocked_o = blocked_i | hit_q | new_hit;
  assign id_o      = id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q   <= '0;
      seen_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (bcast_i.reload) begin
      id_q   <= load_id_i;
      seen_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (bcast_i.step) begin
      if (bcast_i.last) begin
        seen_q <= 1'b0;
        hit_q  <= 1'b0;
        if (active_i && blocked_o) begin
          id_q <= tail_i ? tail_id_i : next_id_i;
        end
      end else begin
        seen_q <= seen_q | match;
        hit_q  <= hit_q | new_hit;
      end
    end
  end

endmodule

// ===== rtl/core/rotating_priority_anchor_select_core.sv =====
`timescale 1ns / 1ps

// Anchor selector for one ranging round. Measurements stream in one item per
// cycle; each is compared against a row of MAX_ANCHORS cells that hold the
// preference order, and the first qualified measurement of the earliest cell
// is kept. The item marked tlast produces one result item in the output
// register on the next cycle (tuser high when an anchor was found); at the same
// edge the chosen id moves to the back of the order by a shift along the row.
// Input is taken every cycle unless the output register still holds an
// untaken result. Writing region_ids or region_count reloads the order and
// drops the round in progress.
module rotating_priority_anchor_select_core #(
  parameter int unsigned MAX_ANCHORS = rpas_pkg::MaxAnchorsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rpas_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [rpas_pkg::CfgDataW-1:0]   cfg_data_i,
  // measurements
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // anchor_id, distance_mm, first_path_rssi, total_rssi
  input  logic [rpas_pkg::TdataW-1:0]     s_axis_tdata,
  input  logic                            s_axis_tlast,
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // chosen_id, chosen_distance_mm, chosen_first_path_rssi, chosen_total_rssi
  output logic [rpas_pkg::TdataW-1:0]     m_axis_tdata,
  // found
  output logic                            m_axis_tuser
);
  import rpas_pkg::*;

  logic [CfgDataW-1:0]     region_ids_q;
  logic [CountW-1:0]       region_count_q;
  logic                    check_mode_q;
  logic signed [DistW-1:0] dist_min_q;
  logic signed [DistW-1:0] dist_max_q;
  logic signed [DiffW-1:0] diff_min_q;
  logic signed [DiffW-1:0] diff_max_q;

  logic                    cfg_fire;
  logic                    reload;
  logic [CfgDataW-1:0]     load_ids;
  logic [CountW-1:0]       active_n;

  logic                    step;
  logic [IdW-1:0]          in_id;
  logic signed [DistW-1:0] in_dist;
  logic signed [RssiW-1:0] in_fp;
  logic signed [RssiW-1:0] in_rx;
  logic signed [DiffW-1:0] in_diff;
  logic                    qual;

  cell_bcast_t             bcast;
  logic [MAX_ANCHORS:0]    blocked;
  logic [MAX_ANCHORS-1:0]  take;
  logic [IdW-1:0]          cell_id [MAX_ANCHORS];
  logic                    take_any;
  logic                    found;

  logic [IdW-1:0]          best_id_q;
  logic [DistW-1:0]        best_dist_q;
  logic [RssiW-1:0]        best_fp_q;
  logic [RssiW-1:0]        best_rx_q;
  logic [IdW-1:0]          sel_id;
  logic [DistW-1:0]        sel_dist;
  logic [RssiW-1:0]        sel_fp;
  logic [RssiW-1:0]        sel_rx;

  logic                    out_valid_q;
  logic [TdataW-1:0]       out_data_q;
  logic                    out_found_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign reload      = cfg_fire & ((cfg_addr_i == REG_REGION_IDS) ||
                                   (cfg_addr_i == REG_REGION_COUNT));
  assign load_ids    = (cfg_addr_i == REG_REGION_IDS) ? cfg_data_i : region_ids_q;

  always_comb begin
    if (region_count_q > CountW'(MAX_ANCHORS)) begin
      active_n = CountW'(MAX_ANCHORS);
    end else begin
      active_n = region_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_ids_q   <= '0;
      region_count_q <= '0;
      check_mode_q   <= 1'b0;
      dist_min_q     <= '0;
      dist_max_q     <= DistW'(24'h7FFFFF);
      diff_min_q     <= DiffW'(200);
      diff_max_q     <= DiffW'(1050);
    end else if (cfg_fire) begin
      unique case (cfg_addr_i)
        REG_REGION_IDS:    region_ids_q   <= cfg_data_i;
        REG_REGION_COUNT:  region_count_q <= cfg_data_i[CountW-1:0];
        REG_CHECK_MODE:    check_mode_q   <= cfg_data_i[0];
        REG_DIST_MIN:      dist_min_q     <= cfg_data_i[DistW-1:0];
        REG_DIST_MAX:      dist_max_q     <= cfg_data_i[DistW-1:0];
        REG_RSSI_DIFF_MIN: diff_min_q     <= cfg_data_i[DiffW-1:0];
        REG_RSSI_DIFF_MAX: diff_max_q     <= cfg_data_i[DiffW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign step          = s_axis_tvalid & s_axis_tready;

  assign in_id   = s_axis_tdata[IdW-1:0];
  assign in_dist = s_axis_tdata[IdW+DistW-1:IdW];
  assign in_fp   = s_axis_tdata[IdW+DistW+RssiW-1:IdW+DistW];
  assign in_rx   = s_axis_tdata[IdW+DistW+2*RssiW-1:IdW+DistW+RssiW];
  assign in_diff = DiffW'(in_rx) - DiffW'(in_fp);

  always_comb begin
    qual = (in_dist >= dist_min_q) && (in_dist <= dist_max_q);
    if (check_mode_q && ((in_diff < diff_min_q) || (in_diff > diff_max_q))) begin
      qual = 1'b0;
    end
  end

  assign bcast.reload = reload;
  assign bcast.step   = step & ~reload;
  assign bcast.last   = s_axis_tlast;
  assign bcast.qual   = qual;
  assign bcast.id     = in_id;

  assign take_any = |take;
  assign found    = blocked[MAX_ANCHORS];
  assign sel_id   = take_any ? in_id : best_id_q;
  assign sel_dist = take_any ? DistW'(in_dist) : best_dist_q;
  assign sel_fp   = take_any ? RssiW'(in_fp) : best_fp_q;
  assign sel_rx   = take_any ? RssiW'(in_rx) : best_rx_q;

  assign blocked[0] = 1'b0;

  for (genvar p = 0; p < MAX_ANCHORS; p++) begin : g_cell
    logic [IdW-1:0] next_id;
    logic           active;
    logic           tail;

    if (p == MAX_ANCHORS - 1) begin : g_end
      assign next_id = '0;
    end else begin : g_mid
      assign next_id = cell_id[p+1];
    end

    assign active = CountW'(p) < active_n;
    assign tail   = CountW'(p + 1) == active_n;

    rpas_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bcast_i   (bcast),
      .active_i  (active),
      .tail_i    (tail),
      .load_id_i (load_ids[IdW*p +: IdW]),
      .next_id_i (next_id),
      .tail_id_i (sel_id),
      .blocked_i (blocked[p]),
      .blocked_o (blocked[p+1]),
      .take_o    (take[p]),
      .id_o      (cell_id[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_id_q   <= '0;
      best_dist_q <= '0;
      best_fp_q   <= '0;
      best_rx_q   <= '0;
    end else if (reload || (bcast.step && bcast.last)) begin
      best_id_q   <= '0;
      best_dist_q <= '0;
      best_fp_q   <= '0;
      best_rx_q   <= '0;
    end else if (bcast.step && take_any) begin
      best_id_q   <= sel_id;
      best_dist_q <= sel_dist;
      best_fp_q   <= sel_fp;
      best_rx_q   <= sel_rx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_data_q  <= '0;
    end else if (bcast.step && bcast.last) begin
      out_valid_q <= 1'b1;
      out_found_q <= found;
      out_data_q  <= found ? {sel_rx, sel_fp, sel_dist, sel_id} : '0;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;

  a_take_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(take))
    else $error("more than one cell claimed the item");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcast.step && bcast.last) |=> m_axis_tvalid)
    else $error("last item gave no result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-found result carries data");

  a_found_needs_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcast.step && bcast.last && found) |-> (active_n != '0))
    else $error("anchor found with empty region");

endmodule

// ===== tb/sv/rotating_priority_anchor_select_core_tb.sv =====
`timescale 1ns / 1ps

module rotating_priority_anchor_select_core_tb;
  import rpas_pkg::*;

  localparam int MaxAnchors = MaxAnchorsDef;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic               last;
    logic signed [15:0] rx;
    logic signed [15:0] fp;
    logic signed [23:0] dist_mm;
    logic [7:0]         id;
  } meas_t;

  typedef struct packed {
    logic               found;
    logic [7:0]         id;
    logic signed [23:0] dist_mm;
    logic signed [15:0] fp;
    logic signed [15:0] rx;
  } choice_t;

  class anchor_choice_board;
    logic [63:0]           region_ids;
    logic [3:0]            region_count;
    logic                  check_mode;
    int                    dist_lo, dist_hi, diff_lo, diff_hi;
    logic [7:0]            order_q [MaxAnchors];
    logic [MaxAnchors-1:0] seen;
    int                    best_pos;
    choice_t               best_pick;
    choice_t               pending_choices [$];
    int                    faults, meas_count, round_count, choice_count;
    int                    found_count, reg_writes;

    function void power_up();
      region_ids   = '0;
      region_count = '0;
      check_mode   = 1'b0;
      dist_lo      = 0;
      dist_hi      = 8388607;
      diff_lo      = 200;
      diff_hi      = 1050;
      reload();
    endfunction

    function void clear_round();
      seen      = '0;
      best_pos  = 15;
      best_pick = '0;
    endfunction

    function void reload();
      for (int k = 0; k < MaxAnchors; k++) order_q[k] = region_ids[8*k +: 8];
      clear_round();
    endfunction

    function int waiting();
      return pending_choices.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] val);
      reg_writes++;
      case (idx)
        REG_REGION_IDS: begin
          region_ids = val;
          reload();
        end
        REG_REGION_COUNT: begin
          region_count = val[3:0];
          reload();
        end
        REG_CHECK_MODE:    check_mode = val[0];
        REG_DIST_MIN:      dist_lo = int'($signed(val[23:0]));
        REG_DIST_MAX:      dist_hi = int'($signed(val[23:0]));
        REG_RSSI_DIFF_MIN: diff_lo = int'($signed(val[16:0]));
        REG_RSSI_DIFF_MAX: diff_hi = int'($signed(val[16:0]));
        default: ;
      endcase
    endfunction

    function void take_measurement(meas_t m);
      int n, dist_mm, diff;
      bit ok;
      choice_t none;
      none = '0;
      meas_count++;
      n = (region_count > MaxAnchors) ? MaxAnchors : int'(region_count);
      dist_mm = int'($signed(m.dist_mm));
      diff = int'($signed(m.rx)) - int'($signed(m.fp));
      ok = (dist_mm >= dist_lo) && (dist_mm <= dist_hi);
      if (check_mode && (diff < diff_lo || diff > diff_hi)) ok = 1'b0;
      for (int p = 0; p < n; p++) begin
        if (order_q[p] == m.id && !seen[p]) begin
          seen[p] = 1'b1;
          if (ok && p < best_pos) begin
            best_pos          = p;
            best_pick.found   = 1'b1;
            best_pick.id      = m.id;
            best_pick.dist_mm = m.dist_mm;
            best_pick.fp      = m.fp;
            best_pick.rx      = m.rx;
          end
        end
      end
      if (m.last) begin
        round_count++;
        if (best_pos < n) begin
          pending_choices = {pending_choices, best_pick};
          for (int k = best_pos; k + 1 < n; k++) order_q[k] = order_q[k+1];
          order_q[n-1] = best_pick.id;
        end else begin
          pending_choices = {pending_choices, none};
        end
        clear_round();
      end
    endfunction

    function string show(choice_t c);
      return $sformatf("found=%0b id=%02h dist=%0d fp=%0d rx=%0d",
                       c.found, c.id, c.dist_mm, c.fp, c.rx);
    endfunction

    function void check_choice(choice_t got);
      choice_t want;
      choice_count++;
      if (got.found) found_count++;
      if (pending_choices.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: %s", show(got));
      end else begin
        want = pending_choices.pop_front();
        if (got.found !== want.found || got.id !== want.id ||
            got.dist_mm !== want.dist_mm ||
            got.fp !== want.fp || got.rx !== want.rx) begin
          faults++;
          if (faults <= 10)
            $display("result mismatch: expected %s, got %s", show(want), show(got));
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [TdataW-1:0]   m_axis_tdata;
  logic                m_axis_tuser;

  anchor_choice_board board;
  bit                 src_idle, sink_idle, hold_req;
  int                 sent, phases;
  logic [63:0]        cur_ids;
  int                 cur_count, cur_dlo, cur_dhi, cur_rlo, cur_rhi;

  rotating_priority_anchor_select_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    meas_t   m;
    choice_t c;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        c.found   = m_axis_tuser;
        c.id      = m_axis_tdata[7:0];
        c.dist_mm = m_axis_tdata[31:8];
        c.fp      = m_axis_tdata[47:32];
        c.rx      = m_axis_tdata[63:48];
        board.check_choice(c);
      end
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_reg_e'(cfg_addr_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        m.id      = s_axis_tdata[7:0];
        m.dist_mm = s_axis_tdata[31:8];
        m.fp      = s_axis_tdata[47:32];
        m.rx      = s_axis_tdata[63:48];
        m.last    = s_axis_tlast;
        board.take_measurement(m);
      end
    end
  end

  initial begin : sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly around the window, often right on its edges
  function automatic int pick_near(int lo, int hi, int flo, int fhi);
    int a, b, r;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    r = $urandom_range(0, 9);
    if (r < 7) return pick_in(clamp(a - 300, flo, fhi), clamp(b + 300, flo, fhi));
    if (r < 9) begin
      case ($urandom_range(0, 3))
        0:       return clamp(lo - 1, flo, fhi);
        1:       return lo;
        2:       return hi;
        default: return clamp(hi + 1, flo, fhi);
      endcase
    end
    return pick_in(flo, fhi);
  endfunction

  function automatic logic [63:0] rand_ids(bit dup);
    logic [63:0] r;
    int a, b;
    r = {$urandom, $urandom};
    if (dup) begin
      for (int j = 0; j < 3; j++) begin
        a = $urandom_range(0, 7);
        b = $urandom_range(0, 7);
        r[8*b +: 8] = r[8*a +: 8];
      end
    end
    return r;
  endfunction

  task automatic send(logic [7:0] id, int dist_mm, int fp, int rx, bit last);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rx[15:0], fp[15:0], dist_mm[23:0], id};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic poke(cfg_reg_e idx, logic [63:0] val, bit more);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (!more) cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [63:0] ids, int count, bit mode, int dlo, int dhi,
                           int rlo, int rhi);
    cur_ids   = ids;
    cur_count = count;
    cur_dlo   = dlo;
    cur_dhi   = dhi;
    cur_rlo   = rlo;
    cur_rhi   = rhi;
    poke(REG_REGION_IDS, ids, 1'b1);
    poke(REG_REGION_COUNT, {60'd0, count[3:0]}, 1'b1);
    poke(REG_CHECK_MODE, {63'd0, mode}, 1'b1);
    poke(REG_DIST_MIN, {40'd0, dlo[23:0]}, 1'b1);
    poke(REG_DIST_MAX, {40'd0, dhi[23:0]}, 1'b1);
    poke(REG_RSSI_DIFF_MIN, {47'd0, rlo[16:0]}, 1'b1);
    poke(REG_RSSI_DIFF_MAX, {47'd0, rhi[16:0]}, 1'b0);
    phases++;
  endtask

  // drain all results, then give the order shift time to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_round(bit noisy);
    int len, act, pos, dist_mm, fp, rx;
    logic [7:0] id;
    bit last;
    len = $urandom_range(1, 9);
    act = (cur_count > MaxAnchors) ? MaxAnchors : cur_count;
    for (int k = 0; k < len; k++) begin
      last = (k == len - 1);
      if (noisy) begin
        id      = 8'($urandom);
        dist_mm = pick_in(-8388608, 8388607);
        fp      = pick_in(-32768, 32767);
        rx      = pick_in(-32768, 32767);
        if ($urandom_range(0, 3) == 0) last = 1'b1;
      end else begin
        if (act > 0 && $urandom_range(0, 7) != 0) begin
          pos = $urandom_range(0, act - 1);
          id  = cur_ids[8*pos +: 8];
        end else begin
          id = 8'($urandom);
        end
        dist_mm = pick_near(cur_dlo, cur_dhi, -8388608, 8388607);
        fp      = ($urandom_range(0, 7) == 0) ? pick_in(-32768, 32767) : pick_in(-12000, -3000);
        rx      = clamp(fp + pick_near(cur_rlo, cur_rhi, -65536, 65535), -32768, 32767);
      end
      send(id, dist_mm, fp, rx, last);
    end
  endtask

  initial begin : stimulus
    int n0, lo, r;
    board = new();
    board.power_up();
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty region straight out of reset
    send(8'h12, 100, -5000, -4500, 1'b1);
    settle();

    // oversized count, field extremes, foreign id, repeated id in a round
    configure(64'hFF7F_8001_C33C_5A00, 15, 1'b0, -8388608, 8388607, -65536, 65535);
    send(8'hFF, 8388607, 32767, -32768, 1'b0);
    send(8'h00, -8388608, -32768, 32767, 1'b0);
    send(8'h77, 0, 0, 0, 1'b0);
    send(8'h00, 5, 0, 0, 1'b1);
    settle();

    // RSSI window, with its edges
    poke(REG_CHECK_MODE, 64'd1, 1'b1);
    poke(REG_RSSI_DIFF_MIN, 64'd200, 1'b1);
    poke(REG_RSSI_DIFF_MAX, 64'd1050, 1'b0);
    send(8'h5A, 1000, -6000, -4949, 1'b0);
    send(8'hC3, 1000, -6000, -4950, 1'b0);
    send(8'h3C, 10, -6000, -5800, 1'b1);
    settle();

    // inverted distance window
    poke(REG_DIST_MIN, 64'd100, 1'b1);
    poke(REG_DIST_MAX, 64'hFFFF9C, 1'b0);
    send(8'h01, 0, -6000, -5500, 1'b1);
    settle();

    // region write drops the round in progress
    poke(REG_DIST_MIN, 64'h800000, 1'b1);
    poke(REG_DIST_MAX, 64'h7FFFFF, 1'b0);
    send(8'h80, 10, -6000, -5500, 1'b0);
    settle();
    poke(REG_REGION_COUNT, 64'd3, 1'b0);
    send(8'hC3, 10, -6000, -5500, 1'b1);
    settle();

    // duplicate ids in the region list
    configure(64'h0000_0000_0022_1122, 3, 1'b0, 0, 1000, 200, 1050);
    send(8'h11, 500, -6000, -5500, 1'b0);
    send(8'h22, 2000, -6000, -5500, 1'b0);
    send(8'h22, 400, -6000, -5500, 1'b1);
    send(8'h22, 300, -6000, -5500, 1'b1);
    send(8'h22, 1000, -6000, -5500, 1'b1);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      case (ph)
        0: configure(rand_ids(1'b0), 8, 1'b0, -8388608, 8388607, -65536, 65535);
        1: configure(rand_ids(1'b0), 4, 1'b1, 0, 20000, 200, 1050);
        2: configure(rand_ids(1'b1), 8, 1'b1, -5000, 5000, -300, 300);
        3: configure(rand_ids(1'b1), 15, 1'b1, -8388608, 8388607, -65536, 65535);
        4: configure(rand_ids(1'b0), 0, 1'b0, 0, 8388607, 200, 1050);
        5: configure(rand_ids(1'b0), 2, 1'b1, -1000, 30000, 900, -900);
        default: begin
          lo = pick_in(-20000, 20000);
          r  = pick_in(-2000, 2000);
          configure(rand_ids(1'($urandom_range(0, 1))), $urandom_range(1, 8),
                    1'($urandom_range(0, 1)), lo, lo + pick_in(-500, 40000),
                    r, r + pick_in(-100, 1500));
        end
      endcase
      // hold the sink off while items keep coming
      if (ph == 2) hold_req = 1'b1;
      n0 = sent;
      while (sent - n0 < 125) send_round($urandom_range(0, 7) == 0);
      settle();
    end

    $display("run covered %0d measurements in %0d rounds over %0d settings (%0d writes)",
             board.meas_count, board.round_count, phases, board.reg_writes);
    $display("results checked: %0d, anchors chosen: %0d, failures: %0d",
             board.choice_count, board.found_count, board.faults);
    if (board.faults == 0 && board.waiting() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== rotating_priority_anchor_select_core.f =====
rtl/core/rpas_pkg.sv
rtl/core/rpas_cell.sv
rtl/core/rotating_priority_anchor_select_core.sv
tb/sv/rotating_priority_anchor_select_core_tb.sv
